// ===== rtl/csv_row_field_splitter_macros.svh =====
// Assertion helpers for the CSV row splitter; the caller must have clk_i and rst_ni.
`ifndef CSV_ROW_FIELD_SPLITTER_MACROS_SVH
`define CSV_ROW_FIELD_SPLITTER_MACROS_SVH

`define CSVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define CSVS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/csvs_pkg.sv =====
package csvs_pkg;

  localparam int unsigned LANES           = 8;
  localparam int unsigned LANE_W          = $clog2(LANES);
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned CNT_W           = 4;
  localparam int unsigned POS_W           = 16;
  localparam int unsigned FIELD_W         = 8;
  localparam int unsigned MAX_FIELD_SLOTS = 256;
  localparam int unsigned FIFO_DEPTH      = 4;
  localparam int unsigned FIFO_AW         = $clog2(FIFO_DEPTH);

  localparam logic [FIELD_W-1:0] FIELD_LIMIT_MAX = FIELD_W'(MAX_FIELD_SLOTS - 1);
  localparam logic [BYTE_W-1:0]  CH_COMMA        = 8'h2C;
  localparam logic [BYTE_W-1:0]  CH_QUOTE        = 8'h22;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_MANY = 2'd1,
    ST_TOO_FEW  = 2'd2
  } status_e;

  // One classified input item: boundaries still to emit plus the row close.
  typedef struct packed {
    logic [LANES-1:0]   comma_mask;
    logic [POS_W-1:0]   base_pos;
    logic [FIELD_W-1:0] base_field;
    logic               row_end;
    logic [POS_W-1:0]   end_offset;
    logic [FIELD_W-1:0] end_field;
    status_e            status;
  } rec_t;

endpackage

// ===== rtl/csvs_front.sv =====
module csvs_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [csvs_pkg::FIELD_W-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic [csvs_pkg::LANES*csvs_pkg::BYTE_W-1:0] in_bytes_i,
  input  logic [csvs_pkg::CNT_W-1:0]     in_count_i,
  input  logic                           in_end_i,
  input  logic                           q_full_i,
  output logic                           in_ready_o,
  output logic                           push_o,
  output csvs_pkg::rec_t                 rec_o
);

  logic [csvs_pkg::FIELD_W-1:0] expected_q;
  logic                         in_quotes_q, in_quotes_d;
  logic [csvs_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [csvs_pkg::FIELD_W-1:0] next_field_q, next_field_d;
  logic                         ovf_q, ovf_d;

  logic [csvs_pkg::CNT_W-1:0]   count;
  logic [csvs_pkg::FIELD_W-1:0] limit;
  logic [csvs_pkg::FIELD_W-1:0] room;
  logic [csvs_pkg::LANES-1:0]   keep;
  logic [csvs_pkg::CNT_W-1:0]   kept;
  logic                         ovf_hit;
  logic                         accept;

  always_comb begin
    logic                       par;
    logic [csvs_pkg::CNT_W-1:0] seen;
    logic [csvs_pkg::BYTE_W-1:0] ch;
    logic                       lane_on;
    count = (in_count_i > csvs_pkg::CNT_W'(csvs_pkg::LANES)) ?
            csvs_pkg::CNT_W'(csvs_pkg::LANES) : in_count_i;
    limit = (expected_q > csvs_pkg::FIELD_LIMIT_MAX) ? csvs_pkg::FIELD_LIMIT_MAX : expected_q;
    room  = (!ovf_q && limit > next_field_q) ? (limit - next_field_q) : '0;
    par     = in_quotes_q;
    seen    = '0;
    kept    = '0;
    ovf_hit = 1'b0;
    keep    = '0;
    for (int i = 0; i < csvs_pkg::LANES; i++) begin
      ch      = in_bytes_i[i*csvs_pkg::BYTE_W +: csvs_pkg::BYTE_W];
      lane_on = csvs_pkg::CNT_W'(i) < count;
      if (lane_on && ch == csvs_pkg::CH_QUOTE) begin
        par = ~par;
      end else if (lane_on && ch == csvs_pkg::CH_COMMA && !par && !ovf_q) begin
        if (csvs_pkg::FIELD_W'(seen) < room) begin
          keep[i] = 1'b1;
          kept    = kept + 1'b1;
        end else begin
          ovf_hit = 1'b1;
        end
        seen = seen + 1'b1;
      end
    end
    in_quotes_d  = par;
    pos_d        = pos_q + csvs_pkg::POS_W'(count);
    next_field_d = next_field_q + csvs_pkg::FIELD_W'(kept);
    ovf_d        = ovf_q | ovf_hit;
  end

  always_comb begin
    rec_o.comma_mask = keep;
    rec_o.base_pos   = pos_q;
    rec_o.base_field = next_field_q;
    rec_o.row_end    = in_end_i;
    rec_o.end_offset = pos_d + 1'b1;
    rec_o.end_field  = expected_q;
    if (ovf_d) begin
      rec_o.status = csvs_pkg::ST_TOO_MANY;
    end else if (next_field_d != expected_q) begin
      rec_o.status = csvs_pkg::ST_TOO_FEW;
    end else begin
      rec_o.status = csvs_pkg::ST_OK;
    end
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept && ((|keep) || in_end_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q   <= csvs_pkg::FIELD_W'(1);
      in_quotes_q  <= 1'b0;
      pos_q        <= '0;
      next_field_q <= csvs_pkg::FIELD_W'(1);
      ovf_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        expected_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (in_end_i) begin
          in_quotes_q  <= 1'b0;
          pos_q        <= '0;
          next_field_q <= csvs_pkg::FIELD_W'(1);
          ovf_q        <= 1'b0;
        end else begin
          in_quotes_q  <= in_quotes_d;
          pos_q        <= pos_d;
          next_field_q <= next_field_d;
          ovf_q        <= ovf_d;
        end
      end
    end
  end

endmodule

// ===== rtl/csvs_fifo.sv =====
module csvs_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  csvs_pkg::rec_t wdata_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output csvs_pkg::rec_t rdata_o
);

  csvs_pkg::rec_t                 mem_q [csvs_pkg::FIFO_DEPTH];
  logic [csvs_pkg::FIFO_AW-1:0]   wptr_q, rptr_q;
  logic [csvs_pkg::FIFO_AW:0]     cnt_q;

  assign full_o  = cnt_q == (csvs_pkg::FIFO_AW+1)'(csvs_pkg::FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/csvs_back.sv =====
`include "csv_row_field_splitter_macros.svh"

module csvs_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  csvs_pkg::rec_t               q_rec_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [csvs_pkg::POS_W-1:0]   out_offset_o,
  output logic [csvs_pkg::FIELD_W-1:0] out_field_o,
  output csvs_pkg::status_e            out_status_o,
  output logic                         out_done_o,
  output logic                         out_last_o
);

  csvs_pkg::rec_t                cur_q;
  logic                          cur_valid_q;
  logic [csvs_pkg::FIELD_W-1:0]  idx_q;

  logic                          out_valid_q;
  logic [csvs_pkg::POS_W-1:0]    offset_q, offset_d;
  logic [csvs_pkg::FIELD_W-1:0]  field_q, field_d;
  csvs_pkg::status_e             status_q, status_d;
  logic                          done_q, done_d;
  logic                          last_q, last_d;

  logic                          load_out, emit, has_comma, finishing;
  logic [csvs_pkg::LANE_W-1:0]   lane;
  logic [csvs_pkg::LANES-1:0]    mask_next;

  assign load_out  = !out_valid_q || out_ready_i;
  assign emit      = cur_valid_q && load_out;
  assign has_comma = |cur_q.comma_mask;
  assign mask_next = cur_q.comma_mask & (cur_q.comma_mask - 1'b1);

  always_comb begin
    lane = '0;
    for (int i = csvs_pkg::LANES - 1; i >= 0; i--) begin
      if (cur_q.comma_mask[i]) begin
        lane = csvs_pkg::LANE_W'(i);
      end
    end
  end

  always_comb begin
    if (has_comma) begin
      offset_d = cur_q.base_pos + csvs_pkg::POS_W'(lane) + 1'b1;
      field_d  = idx_q;
      status_d = csvs_pkg::ST_OK;
      done_d   = 1'b0;
      last_d   = (mask_next == '0) && !cur_q.row_end;
    end else begin
      offset_d = cur_q.end_offset;
      field_d  = cur_q.end_field;
      status_d = cur_q.status;
      done_d   = 1'b1;
      last_d   = 1'b1;
    end
  end

  assign finishing = last_d;
  assign q_pop_o   = q_valid_i && (!cur_valid_q || (emit && finishing));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        cur_valid_q <= 1'b1;
      end else if (emit && finishing) begin
        cur_valid_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_rec_i;
      idx_q <= q_rec_i.base_field;
    end else if (emit && has_comma) begin
      cur_q.comma_mask <= mask_next;
      idx_q            <= idx_q + 1'b1;
    end
    if (emit) begin
      offset_q <= offset_d;
      field_q  <= field_d;
      status_q <= status_d;
      done_q   <= done_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_offset_o = offset_q;
  assign out_field_o  = field_q;
  assign out_status_o = status_q;
  assign out_done_o   = done_q;
  assign out_last_o   = last_q;

  `CSVS_ASSERT(a_empty_rec_closes, cur_valid_q && cur_q.comma_mask == '0 |-> cur_q.row_end, "record with nothing to emit")
  `CSVS_ASSERT(a_done_is_last, out_valid_q && done_q |-> last_q, "row close not last of transfer")
  `CSVS_ASSERT(a_boundary_ok, out_valid_q && !done_q |-> status_q == csvs_pkg::ST_OK, "boundary with status")
  `CSVS_ASSERT_NEVER(a_pop_while_busy, q_pop_o && cur_valid_q && !(emit && finishing), "record overwritten")

endmodule

// ===== rtl/csv_row_field_splitter.sv =====
// CSV row field splitter. Each input transfer carries up to eight row bytes (byte 0 earliest,
// byte_count valid, tlast closes the row). Commas outside double quotes produce one result
// each, up to expected_fields minus one per row, with the offset after the comma and the
// field index; tlast adds a closing result (tuser high) with row length plus one,
// expected_fields and a status. Input is taken every cycle while the four-entry record queue
// has room; the back end emits one result per cycle while m_axis_tready is high, and a
// transfer with no results costs the output nothing.
module csv_row_field_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,   // expected_fields
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // row_bytes[63:0], byte_count[67:64], zero pad
  input  logic        s_axis_tlast,  // row_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // offset[15:0], field_index[23:16], status[25:24], pad
  output logic        m_axis_tuser,  // row_done
  output logic        m_axis_tlast   // last result of the input transfer
);

  logic               push, pop, full, q_valid;
  csvs_pkg::rec_t     rec_in, rec_out;
  csvs_pkg::status_e  status;
  logic [15:0]        offset;
  logic [7:0]         field;

  csvs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_bytes_i  (s_axis_tdata[63:0]),
    .in_count_i  (s_axis_tdata[67:64]),
    .in_end_i    (s_axis_tlast),
    .q_full_i    (full),
    .in_ready_o  (s_axis_tready),
    .push_o      (push),
    .rec_o       (rec_in)
  );

  csvs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (rec_in),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .rdata_o (rec_out)
  );

  csvs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_rec_i      (rec_out),
    .q_pop_o      (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_offset_o (offset),
    .out_field_o  (field),
    .out_status_o (status),
    .out_done_o   (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, status, field, offset};

endmodule
